FILE: rtl/core/srs_pkg.sv
`timescale 1ns / 1ps

package srs_pkg;

    localparam int DEF_STACK_DEPTH = 8;
    localparam int COORD_W         = 16;
    localparam int SY_W            = 18;
    localparam int SH_W            = 15;
    localparam int LEVEL_OUT_W     = 4;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [COORD_W-1:0] w;
        logic        [COORD_W-1:0] h;
    } entry_t;

    typedef struct packed {
        logic shift_dn;
        logic shift_up;
        logic load;
    } cell_ctl_t;

endpackage

FILE: rtl/core/srs_cell.sv
`timescale 1ns / 1ps

module srs_cell
(
    input  logic              clk,
    input  srs_pkg::cell_ctl_t ctl,
    input  srs_pkg::entry_t   from_prev,
    input  srs_pkg::entry_t   from_next,
    output srs_pkg::entry_t   q
);

    srs_pkg::entry_t entry_reg;
    srs_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift_dn || ctl.load)
        begin
            entry_next = from_prev;
        end
        else if (ctl.shift_up)
        begin
            entry_next = from_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

FILE: rtl/core/srs_clip.sv
`timescale 1ns / 1ps

module srs_clip
(
    input  logic                                rect_valid_top,
    input  srs_pkg::entry_t                     top,
    input  logic signed [srs_pkg::COORD_W-1:0]  rect_x,
    input  logic signed [srs_pkg::COORD_W-1:0]  rect_y,
    input  logic signed [srs_pkg::COORD_W-1:0]  rect_w,
    input  logic signed [srs_pkg::COORD_W-1:0]  rect_h,
    output srs_pkg::entry_t                     clipped
);

    localparam int EW = srs_pkg::COORD_W + 1;
    localparam int DW = srs_pkg::COORD_W + 2;

    logic signed [srs_pkg::COORD_W-1:0] lx;
    logic signed [srs_pkg::COORD_W-1:0] ty;
    logic signed [EW-1:0] r_new;
    logic signed [EW-1:0] b_new;
    logic signed [EW-1:0] r_top;
    logic signed [EW-1:0] b_top;
    logic signed [EW-1:0] r_min;
    logic signed [EW-1:0] b_min;
    logic signed [DW-1:0] dw;
    logic signed [DW-1:0] dh;

    always_comb
    begin
        r_new = EW'(rect_x) + EW'(rect_w);
        b_new = EW'(rect_y) + EW'(rect_h);
        r_top = EW'(top.x) + $signed({1'b0, top.w});
        b_top = EW'(top.y) + $signed({1'b0, top.h});
        lx    = (rect_x < top.x) ? top.x : rect_x;
        ty    = (rect_y < top.y) ? top.y : rect_y;
        r_min = (r_new > r_top) ? r_top : r_new;
        b_min = (b_new > b_top) ? b_top : b_new;
        dw    = DW'(r_min) - DW'(lx);
        dh    = DW'(b_min) - DW'(ty);

        if (rect_valid_top)
        begin
            clipped.x = lx;
            clipped.y = ty;
            clipped.w = (dw < 0) ? '0 : dw[srs_pkg::COORD_W-1:0];
            clipped.h = (dh < 0) ? '0 : dh[srs_pkg::COORD_W-1:0];
        end
        else
        begin
            clipped.x = rect_x;
            clipped.y = rect_y;
            clipped.w = rect_w;
            clipped.h = rect_h;
        end
    end

endmodule

FILE: rtl/core/scissor_rect_stack.sv
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// command   in         start, busy            mode, rect_x, rect_y, rect_w, rect_h
// result    out        done (one-cycle word)  scissor_on/x/y/w/h, stack_level
// config    in         cfg_valid, cfg_ready   cfg_data (screen height)
//
// one command per cycle; busy stays low, the top of stack sits in cell zero
// a result follows in the cycle after its command, on done for a single cycle
// a push with non-positive width or height gives no word and changes nothing
// reset clears the level count and the result strobe; stack cells hold junk
// until pushed, the receiver cannot stall the result channel

module scissor_rect_stack
#(
    parameter int STACK_DEPTH = srs_pkg::DEF_STACK_DEPTH
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   mode,
    input  logic signed [srs_pkg::COORD_W-1:0]     rect_x,
    input  logic signed [srs_pkg::COORD_W-1:0]     rect_y,
    input  logic signed [srs_pkg::COORD_W-1:0]     rect_w,
    input  logic signed [srs_pkg::COORD_W-1:0]     rect_h,
    output logic                                   done,
    output logic                                   scissor_on,
    output logic signed [srs_pkg::COORD_W-1:0]     scissor_x,
    output logic signed [srs_pkg::SY_W-1:0]        scissor_y,
    output logic        [srs_pkg::COORD_W-1:0]     scissor_w,
    output logic        [srs_pkg::COORD_W-1:0]     scissor_h,
    output logic        [srs_pkg::LEVEL_OUT_W-1:0] stack_level,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [srs_pkg::SH_W-1:0]        cfg_data
);

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(STACK_DEPTH);

    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic [srs_pkg::SH_W-1:0] sh_reg;

    logic                     done_reg;
    logic                     on_reg;
    logic [LVL_W-1:0]         lvl_out_reg;
    srs_pkg::entry_t          res_reg;

    srs_pkg::entry_t          cell_q [STACK_DEPTH];
    srs_pkg::cell_ctl_t       cell_ctl [STACK_DEPTH];
    srs_pkg::entry_t          clipped;
    srs_pkg::entry_t          below;

    logic accept;
    logic do_pop;
    logic do_push;
    logic has_top;
    logic is_full;
    logic signed [srs_pkg::SY_W-1:0] sy;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign do_pop    = accept && (mode == srs_pkg::MODE_POP);
    assign do_push   = accept && (mode == srs_pkg::MODE_PUSH) && (rect_w > 0) && (rect_h > 0);
    assign has_top   = (level_reg != '0);
    assign is_full   = (level_reg == FULL_LVL);

    srs_clip u_clip
    (
        .rect_valid_top (has_top),
        .top            (cell_q[0]),
        .rect_x         (rect_x),
        .rect_y         (rect_y),
        .rect_w         (rect_w),
        .rect_h         (rect_h),
        .clipped        (clipped)
    );

    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++)
        begin : g_cell
            srs_pkg::entry_t prev_e;
            srs_pkg::entry_t next_e;

            if (i == 0)
            begin : g_first
                assign prev_e = clipped;
            end
            else
            begin : g_mid
                assign prev_e = cell_q[i-1];
            end

            if (i == STACK_DEPTH - 1)
            begin : g_last
                assign next_e = cell_q[i];
            end
            else
            begin : g_inner
                assign next_e = cell_q[i+1];
            end

            assign cell_ctl[i].shift_dn = do_push && !is_full;
            assign cell_ctl[i].shift_up = do_pop;
            assign cell_ctl[i].load     = (i == 0) ? (do_push && is_full) : 1'b0;

            srs_cell u_cell
            (
                .clk       (clk),
                .ctl       (cell_ctl[i]),
                .from_prev (prev_e),
                .from_next (next_e),
                .q         (cell_q[i])
            );
        end

        if (STACK_DEPTH > 1)
        begin : g_below
            assign below = cell_q[1];
        end
        else
        begin : g_below_one
            assign below = cell_q[0];
        end
    endgenerate

    always_comb
    begin
        level_next = level_reg;
        if (do_pop && has_top)
        begin
            level_next = level_reg - 1'b1;
        end
        else if (do_push && !is_full)
        begin
            level_next = level_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= '0;
            sh_reg      <= '0;
            done_reg    <= 1'b0;
            on_reg      <= 1'b0;
            lvl_out_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
            done_reg  <= do_pop || do_push;
            if (cfg_valid && cfg_ready)
            begin
                sh_reg <= cfg_data;
            end
            if (do_pop || do_push)
            begin
                lvl_out_reg <= level_next;
                on_reg      <= (level_next != '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            res_reg <= clipped;
        end
        else if (do_pop)
        begin
            res_reg <= (level_next != '0) ? below : '0;
        end
    end

    assign sy = $signed({3'b000, sh_reg}) - srs_pkg::SY_W'(res_reg.y)
              - $signed({2'b00, res_reg.h});

    assign done        = done_reg;
    assign scissor_on  = on_reg;
    assign scissor_x   = res_reg.x;
    assign scissor_y   = on_reg ? sy : '0;
    assign scissor_w   = res_reg.w;
    assign scissor_h   = res_reg.h;
    assign stack_level = srs_pkg::LEVEL_OUT_W'(lvl_out_reg);

endmodule

FILE: rtl/core/srs_checker.sv
`timescale 1ns / 1ps

module srs_checker
(
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic                                   mode,
    input logic                                   done,
    input logic                                   scissor_on,
    input logic signed [srs_pkg::COORD_W-1:0]     scissor_x,
    input logic signed [srs_pkg::SY_W-1:0]        scissor_y,
    input logic        [srs_pkg::COORD_W-1:0]     scissor_w,
    input logic        [srs_pkg::COORD_W-1:0]     scissor_h
);

    // a pop always gives a word on the next cycle
    a_pop_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == srs_pkg::MODE_POP)) |=> done)
        else $error("pop gave no result word");

    // no word without a command in the cycle before
    a_no_spurious_word: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result word without command");

    // an empty stack reports a zero rectangle
    a_off_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !scissor_on) |->
        (scissor_x == '0 && scissor_y == '0 && scissor_w == '0 && scissor_h == '0))
        else $error("scissor off with non-zero rectangle");

    // a push is never reported with scissoring off
    a_push_on: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == srs_pkg::MODE_PUSH)) |=> (!done || scissor_on))
        else $error("push reported with scissor off");

endmodule

bind scissor_rect_stack srs_checker u_srs_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .done       (done),
    .scissor_on (scissor_on),
    .scissor_x  (scissor_x),
    .scissor_y  (scissor_y),
    .scissor_w  (scissor_w),
    .scissor_h  (scissor_h)
);
